### src/y86fd_pkg.sv
// Package for the Y86-64 fetch decoder: payload structs, status and
// instruction codes, and the decode helper functions.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package y86fd_pkg;

  // Status codes of a result beat
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_END     = 3'd1;
  localparam logic [2:0] STAT_BAD_OP  = 3'd2;
  localparam logic [2:0] STAT_BAD_FUN = 3'd3;
  localparam logic [2:0] STAT_BAD_REG = 3'd4;
  localparam logic [2:0] STAT_MEM_ERR = 3'd5;

  // Instruction codes
  localparam logic [3:0] IC_HALT   = 4'h0;
  localparam logic [3:0] IC_NOP    = 4'h1;
  localparam logic [3:0] IC_RRMOVQ = 4'h2;
  localparam logic [3:0] IC_IRMOVQ = 4'h3;
  localparam logic [3:0] IC_RMMOVQ = 4'h4;
  localparam logic [3:0] IC_MRMOVQ = 4'h5;
  localparam logic [3:0] IC_OPQ    = 4'h6;
  localparam logic [3:0] IC_JXX    = 4'h7;
  localparam logic [3:0] IC_CALL   = 4'h8;
  localparam logic [3:0] IC_RET    = 4'h9;
  localparam logic [3:0] IC_PUSHQ  = 4'ha;
  localparam logic [3:0] IC_POPQ   = 4'hb;

  localparam logic [3:0] REG_NONE  = 4'hf;
  localparam logic [3:0] FUN_MAX   = 4'd6;
  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_SHORT = 4'd1;
  localparam logic [3:0] LEN_REGS  = 4'd2;
  localparam logic [3:0] LEN_JUMP  = 4'd9;
  localparam logic [3:0] LEN_LONG  = 4'd10;
  localparam logic [1:0] HALT_QUIET = 2'd3;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] instr_pc;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic        regs_valid;
    logic [63:0] const_value;
    logic        const_valid;
    logic [63:0] next_pc;
    logic [7:0]  bad_byte;
    logic [3:0]  bytes_read;
  } result_t;

  // Decoded instruction record passed from front to back; next_pc is
  // formed in the back as instr_pc plus pc_add.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] instr_pc;
    logic [7:0]  opcode;
    logic [7:0]  reg_byte;
    logic        regs_valid;
    logic [63:0] const_value;
    logic        const_valid;
    logic [3:0]  pc_add;
    logic [7:0]  bad_byte;
    logic [3:0]  bytes_read;
  } decoded_t;

  function automatic logic [3:0] instr_len(input logic [3:0] ic);
    logic [3:0] len;
    case (ic)
      IC_HALT, IC_NOP, IC_RET: len = LEN_SHORT;
      IC_RRMOVQ, IC_OPQ, IC_PUSHQ, IC_POPQ: len = LEN_REGS;
      IC_IRMOVQ, IC_RMMOVQ, IC_MRMOVQ: len = LEN_LONG;
      IC_JXX, IC_CALL: len = LEN_JUMP;
      default: len = LEN_NONE;
    endcase
    return len;
  endfunction

  function automatic logic fun_ok(input logic [3:0] ic, input logic [3:0] fn);
    logic ok;
    if (ic == IC_RRMOVQ || ic == IC_OPQ || ic == IC_JXX) begin
      ok = (fn <= FUN_MAX);
    end else begin
      ok = (fn == 4'd0);
    end
    return ok;
  endfunction

  function automatic logic regs_ok(input logic [3:0] ic, input logic [7:0] rbyte);
    logic ok;
    case (ic)
      IC_RRMOVQ, IC_RMMOVQ, IC_MRMOVQ, IC_OPQ:
        ok = (rbyte[7:4] != REG_NONE) && (rbyte[3:0] != REG_NONE);
      IC_IRMOVQ: ok = (rbyte[7:4] == REG_NONE) && (rbyte[3:0] != REG_NONE);
      IC_PUSHQ, IC_POPQ: ok = (rbyte[7:4] != REG_NONE) && (rbyte[3:0] == REG_NONE);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

### src/y86fd_front.sv
// Front end of the fetch decoder: byte parser with PC, halt run and stop state.
// Emits at most one decoded record per instruction or error. Uses y86fd_pkg.
`default_nettype none

module y86fd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire y86fd_pkg::item_t   item,
  input  wire logic               start_pc_we,
  input  wire logic [63:0]        start_pc,
  output logic                    emit,
  output y86fd_pkg::decoded_t     rec
);
  import y86fd_pkg::*;

  logic [63:0] pc;
  logic [7:0]  opcode;
  logic [7:0]  reg_byte;
  logic [63:0] accum;
  logic [3:0]  pos;
  logic [1:0]  halt_run;
  logic        stopped;

  logic [63:0] pc_next;
  logic [7:0]  opcode_next;
  logic [7:0]  reg_byte_next;
  logic [63:0] accum_next;
  logic [3:0]  pos_next;
  logic [1:0]  halt_run_next;
  logic        stopped_next;

  logic [7:0]  b;
  logic [3:0]  b_len;
  logic [3:0]  cur_len;
  logic        has_regs;
  logic [3:0]  skip;
  logic [3:0]  lane_full;
  logic [2:0]  lane;
  logic [3:0]  pos_inc;

  assign b        = item.code_byte;
  assign b_len    = instr_len(b[7:4]);
  assign cur_len  = instr_len(opcode[7:4]);
  assign has_regs = (cur_len == LEN_REGS) || (cur_len == LEN_LONG);
  assign skip     = has_regs ? 4'd2 : 4'd1;
  assign lane_full = pos - skip;
  assign lane     = lane_full[2:0];
  assign pos_inc  = pos + 4'd1;

  // Parse one accepted byte
  always_comb begin
    pc_next       = pc;
    opcode_next   = opcode;
    reg_byte_next = reg_byte;
    accum_next    = accum;
    pos_next      = pos;
    halt_run_next = halt_run;
    stopped_next  = stopped;
    emit          = 1'b0;
    rec           = '0;
    rec.instr_pc  = pc;

    if (accept && !stopped) begin
      if (pos == 4'd0) begin
        if (item.end_of_file) begin
          emit         = 1'b1;
          rec.status   = STAT_END;
          stopped_next = 1'b1;
        end else if (b_len == LEN_NONE) begin
          emit           = 1'b1;
          rec.status     = STAT_BAD_OP;
          rec.opcode     = b;
          rec.bad_byte   = b;
          rec.bytes_read = 4'd1;
          stopped_next   = 1'b1;
        end else if (!fun_ok(b[7:4], b[3:0])) begin
          emit           = 1'b1;
          rec.status     = STAT_BAD_FUN;
          rec.opcode     = b;
          rec.bad_byte   = b;
          rec.bytes_read = 4'd1;
          rec.pc_add     = 4'd1;
          stopped_next   = 1'b1;
        end else begin
          opcode_next   = b;
          reg_byte_next = 8'd0;
          accum_next    = 64'd0;
          if (b_len == LEN_SHORT) begin
            if (b[7:4] == IC_HALT) begin
              if (halt_run != HALT_QUIET) begin
                halt_run_next = halt_run + 2'd1;
              end
            end else begin
              halt_run_next = 2'd0;
            end
            // drop the third and later halts of a run
            emit           = !(b[7:4] == IC_HALT && halt_run >= 2'd2);
            rec.status     = STAT_OK;
            rec.opcode     = b;
            rec.pc_add     = 4'd1;
            rec.bytes_read = 4'd1;
            pc_next        = pc + 64'd1;
          end else begin
            halt_run_next = 2'd0;
            pos_next      = 4'd1;
          end
        end
      end else if (item.end_of_file) begin
        emit             = 1'b1;
        rec.status       = STAT_MEM_ERR;
        rec.opcode       = opcode;
        rec.regs_valid   = has_regs && (pos >= 4'd2);
        rec.reg_byte     = rec.regs_valid ? reg_byte : 8'd0;
        rec.const_value  = accum;
        rec.const_valid  = (pos > skip);
        rec.pc_add       = cur_len;
        rec.bytes_read   = pos;
        stopped_next     = 1'b1;
      end else if (has_regs && pos == 4'd1 && !regs_ok(opcode[7:4], b)) begin
        emit           = 1'b1;
        rec.status     = STAT_BAD_REG;
        rec.opcode     = opcode;
        rec.reg_byte   = b;
        rec.pc_add     = cur_len;
        rec.bad_byte   = b;
        rec.bytes_read = 4'd2;
        stopped_next   = 1'b1;
      end else begin
        if (has_regs && pos == 4'd1) begin
          reg_byte_next = b;
        end else begin
          accum_next[{lane, 3'b000} +: 8] = accum[{lane, 3'b000} +: 8] | b;
        end
        pos_next = pos_inc;
        if (pos_inc >= cur_len) begin
          emit            = 1'b1;
          rec.status      = STAT_OK;
          rec.opcode      = opcode;
          rec.reg_byte    = has_regs ? reg_byte_next : 8'd0;
          rec.regs_valid  = has_regs;
          rec.const_value = accum_next;
          rec.const_valid = (cur_len >= LEN_JUMP);
          rec.pc_add      = cur_len;
          rec.bytes_read  = cur_len;
          pc_next         = pc + {60'd0, cur_len};
          pos_next        = 4'd0;
        end
      end
    end

    // reload the PC on a start address write
    if (start_pc_we) begin
      pc_next = start_pc;
    end
  end

  // Advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= 64'd0;
      pos      <= 4'd0;
      halt_run <= 2'd0;
      stopped  <= 1'b0;
      opcode   <= 8'd0;
      reg_byte <= 8'd0;
      accum    <= 64'd0;
    end else begin
      pc       <= pc_next;
      pos      <= pos_next;
      halt_run <= halt_run_next;
      stopped  <= stopped_next;
      opcode   <= opcode_next;
      reg_byte <= reg_byte_next;
      accum    <= accum_next;
    end
  end

endmodule

`default_nettype wire

### src/y86fd_queue.sv
// Short queue of decoded records between the front and the back end.
// Uses y86fd_pkg for the record type.
`default_nettype none

module y86fd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire y86fd_pkg::decoded_t wr_data,
  input  wire logic                rd_en,
  output y86fd_pkg::decoded_t      rd_data,
  output logic                     q_full,
  output logic                     q_empty
);
  import y86fd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  decoded_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == FULL_COUNT);
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Store a record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/y86fd_back.sv
// Back end of the fetch decoder: forms valP and result fields and holds
// the result beat in an output register. Uses y86fd_pkg.
`default_nettype none

module y86fd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire y86fd_pkg::decoded_t rec,
  output logic                     q_rd,
  input  wire logic                pop,
  output logic                     empty,
  output y86fd_pkg::result_t       result
);
  import y86fd_pkg::*;

  logic    out_valid;
  logic    load;
  result_t formed;

  assign load  = !q_empty && (!out_valid || pop);
  assign q_rd  = load;
  assign empty = !out_valid;

  // Build the result beat from a decoded record
  always_comb begin
    formed.status      = rec.status;
    formed.instr_pc    = rec.instr_pc;
    formed.icode       = rec.opcode[7:4];
    formed.ifun        = rec.opcode[3:0];
    formed.reg_a       = rec.reg_byte[7:4];
    formed.reg_b       = rec.reg_byte[3:0];
    formed.regs_valid  = rec.regs_valid;
    formed.const_value = rec.const_value;
    formed.const_valid = rec.const_valid;
    formed.next_pc     = rec.instr_pc + {60'd0, rec.pc_add};
    formed.bad_byte    = rec.bad_byte;
    formed.bytes_read  = rec.bytes_read;
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= formed;
    end
  end

endmodule

`default_nettype wire

### src/y86_fetch_decoder_core.sv
// Y86-64 fetch decoder: one object-code byte accepted per cycle while the queue is not full.
// A finished instruction's record is written into the queue, then loaded into
// the back end's output register when that register is free.
// Throughput is set by the one-byte parse step in the front end and one result per cycle
// out of the output register while popped; input stalls when the queue is full.
// Reset (rst, synchronous) clears the PC to 0, the parse state, the queue and the output.
`default_nettype none

module y86_fetch_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire y86fd_pkg::item_t   item,
  input  wire logic               start_pc_we,
  input  wire logic [63:0]        start_pc,
  output logic                    empty,
  input  wire logic               pop,
  output y86fd_pkg::result_t      result
);
  import y86fd_pkg::*;

  logic     accept;
  logic     emit;
  decoded_t front_rec;
  decoded_t queue_rec;
  logic     q_full;
  logic     q_empty;
  logic     q_rd;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Parse bytes
  y86fd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .start_pc_we (start_pc_we),
    .start_pc    (start_pc),
    .emit        (emit),
    .rec         (front_rec)
  );

  // Decouple front and back
  y86fd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (emit),
    .wr_data (front_rec),
    .rd_en   (q_rd),
    .rd_data (queue_rec),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Form and hold results
  y86fd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .rec     (queue_rec),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire
